/* rtl/smc_pkg.sv */
// Stepper move controller: shared types, codes and constants.
// Used by every module of the stepper move controller; depends on nothing.
package smc_pkg;

   localparam int CMD_W     = 2;
   localparam int MM_W      = 10;
   localparam int SPM_W     = 11;
   localparam int MAXS_W    = 16;
   localparam int POS_W     = 18;
   localparam int GOAL_W    = 21;
   localparam int CNT_W     = 20;
   localparam int TRAVEL_W  = 17;
   localparam int STAT_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int DIV_STEPS = CNT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_HOME = 2'd2;

   localparam logic [STAT_W-1:0] STAT_NONE      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_HOME_OK   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_HOME_FAIL = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_PER_MM = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STEPS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENDSTOP_LVL  = 2'd2;

   localparam logic [SPM_W-1:0]  SPM_RESET  = 11'd80;
   localparam logic [MAXS_W-1:0] MAXS_RESET = 16'd10000;

   localparam logic [CNT_W-1:0] PULSE_TIME     = 20'd200;
   localparam logic [CNT_W-1:0] MIN_QUOTIENT   = 20'd400;
   localparam logic [CNT_W-1:0] DIV_DIVIDEND   = 20'd1000000;
   localparam logic [CNT_W-1:0] SEEK_PERIOD    = 20'd500;
   localparam logic [CNT_W-1:0] BACKOFF_PERIOD = 20'd3200;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_MOVE    = 2'd1,
      MODE_SEEK    = 2'd2,
      MODE_BACKOFF = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CHK,
      ST_DIV
   } ctl_state_type;

   typedef enum logic [2:0] {
      DP_NOP,
      DP_LATCH,
      DP_MUL,
      DP_REPORT,
      DP_DIV_START,
      DP_EXEC,
      DP_MOVE_FIN
   } dp_op_type;

   typedef struct packed {
      logic is_move;
      logic goal_eq_pos;
      logic div_done;
   } dp_status_type;

endpackage

/* rtl/smc_div.sv */
// Stepper move controller: restoring divider, constant dividend over a divisor.
// One quotient bit per cycle. Depends on smc_pkg.
module smc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [smc_pkg::GOAL_W-1:0]  divisor,
   output logic                        done,
   output logic [smc_pkg::CNT_W-1:0]   quotient
);
   import smc_pkg::*;

   logic                  active_ff, active_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]      quo_ff, quo_in;
   logic [GOAL_W-1:0]     rem_ff, rem_in;
   logic [GOAL_W-1:0]     dvs_ff, dvs_in;
   logic [GOAL_W:0]       shifted;
   logic [GOAL_W:0]       diff;

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      shifted   = {rem_ff, quo_ff[CNT_W-1]};
      diff      = shifted - {1'b0, dvs_ff};
      if (start) begin
         active_in = 1'b1;
         cnt_in    = '0;
         quo_in    = DIV_DIVIDEND;
         rem_in    = '0;
         dvs_in    = divisor;
      end else if (active_ff) begin
         if (!diff[GOAL_W]) begin
            rem_in = diff[GOAL_W-1:0];
            quo_in = {quo_ff[CNT_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[GOAL_W-1:0];
            quo_in = {quo_ff[CNT_W-2:0], 1'b0};
         end
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end else begin
            cnt_in = cnt_ff + DIV_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/smc_ctl.sv */
// Stepper move controller: sequencing state machine and result valid flag.
// Drives datapath operations; depends on smc_pkg.
module smc_ctl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output smc_pkg::dp_op_type     dp_op,
   input  smc_pkg::dp_status_type dp_status
);
   import smc_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          load_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      dp_op     = DP_NOP;
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               dp_op    = DP_LATCH;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (dp_status.is_move) begin
               dp_op    = DP_MUL;
               state_in = ST_CHK;
            end else begin
               dp_op    = DP_EXEC;
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CHK: begin
            if (dp_status.goal_eq_pos) begin
               dp_op    = DP_REPORT;
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end else begin
               dp_op    = DP_DIV_START;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (dp_status.div_done) begin
               dp_op    = DP_MOVE_FIN;
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/smc_dp.sv */
// Stepper move controller: config registers, motion state, result register.
// Depends on smc_pkg and instantiates smc_div.
module smc_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  smc_pkg::dp_op_type             dp_op,
   output smc_pkg::dp_status_type         dp_status,
   input  logic [smc_pkg::CMD_W-1:0]      req_command,
   input  logic [smc_pkg::MM_W-1:0]       req_target_mm,
   input  logic [smc_pkg::MM_W-1:0]       req_speed_mms,
   input  logic                           req_home_dir,
   input  logic                           req_endstop,
   input  logic                           csr_write,
   input  logic [smc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [smc_pkg::CSR_DAT_W-1:0]  csr_data,
   output logic                           rsp_step_pulse,
   output logic                           rsp_direction,
   output logic                           rsp_enable,
   output logic signed [smc_pkg::POS_W-1:0] rsp_position,
   output logic                           rsp_busy_res,
   output logic [smc_pkg::STAT_W-1:0]     rsp_status
);
   import smc_pkg::*;

   // configuration
   logic [SPM_W-1:0]    spm_ff;
   logic [MAXS_W-1:0]   maxs_ff;
   logic                esl_ff;

   // motion state
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [GOAL_W-1:0]   goal_ff, goal_in;
   logic [CNT_W-1:0]    intv_ff, intv_in;
   logic [CNT_W-1:0]    tick_ff, tick_in;
   mode_type            mode_ff, mode_in;
   logic                dir_ff, dir_in;
   logic [TRAVEL_W-1:0] travel_ff, travel_in;
   logic                hdir_ff, hdir_in;

   // latched beat and products
   logic [CMD_W-1:0]    cmd_ff;
   logic [MM_W-1:0]     tmm_ff;
   logic [MM_W-1:0]     smm_ff;
   logic                bhdir_ff;
   logic                endstop_ff;
   logic [GOAL_W-1:0]   goal_prod_ff;
   logic [GOAL_W-1:0]   rate_ff;
   logic [GOAL_W-1:0]   rate_prod;

   // result values, loaded into the rsp registers
   logic                step_res;
   logic [STAT_W-1:0]   stat_res;

   // divider
   logic                div_done;
   logic [CNT_W-1:0]    quotient;

   // helpers
   logic                hit;
   logic [POS_W-1:0]    pos_inc;
   logic [POS_W-1:0]    pos_dec;
   logic [POS_W-1:0]    move_pos;
   logic [CNT_W-1:0]    tick_inc;
   logic                goal_gt_pos;
   logic                act_dir;
   logic [TRAVEL_W-1:0] travel_next;
   logic [CNT_W-1:0]    period;
   logic                load_rsp;

   smc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dp_op == DP_DIV_START),
      .divisor  (rate_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign hit         = (endstop_ff == esl_ff);
   assign pos_inc     = pos_ff + POS_W'(1);
   assign pos_dec     = pos_ff - POS_W'(1);
   assign move_pos    = dir_ff ? pos_inc : pos_dec;
   assign tick_inc    = tick_ff + CNT_W'(1);
   assign goal_gt_pos = pos_ff[POS_W-1] ||
                        (goal_prod_ff > GOAL_W'(pos_ff));
   assign rate_prod   = GOAL_W'(smm_ff) * GOAL_W'(spm_ff);

   assign dp_status.is_move     = (cmd_ff == CMD_MOVE);
   assign dp_status.goal_eq_pos = !pos_ff[POS_W-1] &&
                                  (goal_prod_ff == GOAL_W'(pos_ff));
   assign dp_status.div_done    = div_done;

   always_comb begin
      pos_in      = pos_ff;
      goal_in     = goal_ff;
      intv_in     = intv_ff;
      tick_in     = tick_ff;
      mode_in     = mode_ff;
      dir_in      = dir_ff;
      travel_in   = travel_ff;
      hdir_in     = hdir_ff;
      step_res    = 1'b0;
      stat_res    = STAT_NONE;
      act_dir     = (mode_ff == MODE_SEEK && hit) ? !hdir_ff : dir_ff;
      travel_next = ((mode_ff == MODE_SEEK && hit) ? '0 : travel_ff) + TRAVEL_W'(1);
      period      = BACKOFF_PERIOD;
      case (dp_op)
         DP_EXEC: begin
            case (cmd_ff)
               CMD_HOME: begin
                  hdir_in   = bhdir_ff;
                  dir_in    = bhdir_ff;
                  travel_in = '0;
                  tick_in   = '0;
                  mode_in   = MODE_SEEK;
               end
               CMD_TICK: begin
                  case (mode_ff)
                     MODE_MOVE: begin
                        if (tick_inc > intv_ff) begin
                           tick_in = '0;
                           if (hit) begin
                              mode_in = MODE_IDLE;
                           end else begin
                              pos_in   = move_pos;
                              step_res = 1'b1;
                              if (move_pos[POS_W-1] || move_pos == '0 ||
                                  move_pos[TRAVEL_W-1:0] >= TRAVEL_W'(maxs_ff) ||
                                  goal_ff == GOAL_W'(move_pos)) begin
                                 mode_in = MODE_IDLE;
                              end
                           end
                        end else begin
                           tick_in = tick_inc;
                        end
                     end
                     MODE_SEEK, MODE_BACKOFF: begin
                        if (tick_ff == '0) begin
                           if (mode_ff == MODE_BACKOFF && !hit) begin
                              dir_in   = hdir_ff;
                              mode_in  = MODE_IDLE;
                              pos_in   = '0;
                              stat_res = STAT_HOME_OK;
                           end else begin
                              dir_in    = act_dir;
                              pos_in    = act_dir ? pos_inc : pos_dec;
                              step_res  = 1'b1;
                              travel_in = travel_next;
                              if (hit) begin
                                 mode_in = MODE_BACKOFF;
                              end
                              if (travel_next >= TRAVEL_W'(maxs_ff)) begin
                                 mode_in  = MODE_IDLE;
                                 stat_res = STAT_HOME_FAIL;
                              end
                           end
                        end
                        if (mode_in == MODE_SEEK) begin
                           period = SEEK_PERIOD;
                        end
                        if (tick_inc >= period || mode_in == MODE_IDLE) begin
                           tick_in = '0;
                        end else begin
                           tick_in = tick_inc;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               default: begin
               end
            endcase
         end
         DP_MOVE_FIN: begin
            goal_in = goal_prod_ff;
            dir_in  = goal_gt_pos;
            intv_in = (quotient < MIN_QUOTIENT) ? PULSE_TIME : quotient - PULSE_TIME;
            tick_in = '0;
            mode_in = MODE_MOVE;
         end
         default: begin
         end
      endcase
   end

   assign load_rsp = (dp_op == DP_EXEC) || (dp_op == DP_REPORT) ||
                     (dp_op == DP_MOVE_FIN);

   always_ff @(posedge clock) begin
      if (reset) begin
         spm_ff    <= SPM_RESET;
         maxs_ff   <= MAXS_RESET;
         esl_ff    <= 1'b0;
         pos_ff    <= '0;
         goal_ff   <= '0;
         intv_ff   <= '0;
         tick_ff   <= '0;
         mode_ff   <= MODE_IDLE;
         dir_ff    <= 1'b1;
         travel_ff <= '0;
         hdir_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_STEPS_PER_MM: spm_ff  <= csr_data[SPM_W-1:0];
               CSR_MAX_STEPS:    maxs_ff <= csr_data[MAXS_W-1:0];
               CSR_ENDSTOP_LVL:  esl_ff  <= csr_data[0];
               default: begin
               end
            endcase
         end
         pos_ff    <= pos_in;
         goal_ff   <= goal_in;
         intv_ff   <= intv_in;
         tick_ff   <= tick_in;
         mode_ff   <= mode_in;
         dir_ff    <= dir_in;
         travel_ff <= travel_in;
         hdir_ff   <= hdir_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_op == DP_LATCH) begin
         cmd_ff     <= req_command;
         tmm_ff     <= req_target_mm;
         smm_ff     <= req_speed_mms;
         bhdir_ff   <= req_home_dir;
         endstop_ff <= req_endstop;
      end
      if (dp_op == DP_MUL) begin
         goal_prod_ff <= GOAL_W'(tmm_ff) * GOAL_W'(spm_ff);
         rate_ff      <= (rate_prod == '0) ? GOAL_W'(1) : rate_prod;
      end
      if (load_rsp) begin
         rsp_step_pulse <= step_res;
         rsp_direction  <= dir_in;
         rsp_enable     <= (mode_in != MODE_IDLE);
         rsp_busy_res   <= (mode_in != MODE_IDLE);
         rsp_position   <= signed'(pos_in);
         rsp_status     <= stat_res;
      end
   end

endmodule

/* rtl/stepper_move_controller.sv */
// Stepper move controller top level: step/direction generation with homing.
// Depends on smc_pkg; instantiates smc_ctl and smc_dp.
//
//   channel  handshake              payload
//   req      req_valid/req_ready    command, target_mm, speed_mms, home_dir, endstop
//   rsp      rsp_valid/rsp_ready    step_pulse, direction, enable, position,
//                                   busy_res, status
//   csr      csr_valid/csr_ready    csr_index, csr_data (always ready)
//
// Tick, home and unused-command beats go from ST_IDLE through ST_EXEC back to ST_IDLE.
// A move beat goes through ST_EXEC and ST_CHK, back to ST_IDLE if the goal equals the
// position, else on through ST_DIV, where the divide runs one quotient bit per cycle.
// The next req beat is taken in ST_IDLE while the rsp register is empty or being drained.
// Synchronous reset restores the register defaults and an idle motor; no clearing pass.
module stepper_move_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [smc_pkg::CMD_W-1:0]         req_command,
   input  logic [smc_pkg::MM_W-1:0]          req_target_mm,
   input  logic [smc_pkg::MM_W-1:0]          req_speed_mms,
   input  logic                              req_home_dir,
   input  logic                              req_endstop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_step_pulse,
   output logic                              rsp_direction,
   output logic                              rsp_enable,
   output logic signed [smc_pkg::POS_W-1:0]  rsp_position,
   output logic                              rsp_busy_res,
   output logic [smc_pkg::STAT_W-1:0]        rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [smc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [smc_pkg::CSR_DAT_W-1:0]     csr_data
);
   import smc_pkg::*;

   dp_op_type     dp_op;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   smc_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_op     (dp_op),
      .dp_status (dp_status)
   );

   smc_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .dp_op          (dp_op),
      .dp_status      (dp_status),
      .req_command    (req_command),
      .req_target_mm  (req_target_mm),
      .req_speed_mms  (req_speed_mms),
      .req_home_dir   (req_home_dir),
      .req_endstop    (req_endstop),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_step_pulse (rsp_step_pulse),
      .rsp_direction  (rsp_direction),
      .rsp_enable     (rsp_enable),
      .rsp_position   (rsp_position),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_status     (rsp_status)
   );

endmodule

/* sim/tb.sv */
// Testbench for stepper_move_controller: moves, homing, register writes and idle ticks.
// Depends on smc_pkg and the RTL; every rsp beat is checked against an in-bench
// model of position, direction, mode and homing status.
module tb;
   import smc_pkg::*;

   localparam int LIMIT_CYCLES = 4000000;
   localparam int RANDOM_ITEMS = 800;
   localparam int PHASES = 6;
   localparam int MAX_PRINTS = 100;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic step_pulse;
      logic direction;
      logic enable;
      logic [POS_W-1:0] position;
      logic busy;
      logic [STAT_W-1:0] status;
   } motor_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [CMD_W-1:0] req_command = CMD_TICK;
   logic [MM_W-1:0] req_target_mm = '0;
   logic [MM_W-1:0] req_speed_mms = '0;
   logic req_home_dir = 1'b0;
   logic req_endstop = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_step_pulse;
   logic rsp_direction;
   logic rsp_enable;
   logic signed [POS_W-1:0] rsp_position;
   logic rsp_busy_res;
   logic [STAT_W-1:0] rsp_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   // motor model: registers and state
   logic [SPM_W-1:0] spm_cfg = SPM_RESET;
   logic [MAXS_W-1:0] max_steps_cfg = MAXS_RESET;
   logic endstop_lvl_cfg = 1'b0;
   logic [POS_W-1:0] pos_now = '0;
   logic [GOAL_W-1:0] goal_now = '0;
   logic [CNT_W-1:0] interval_now = '0;
   logic [CNT_W-1:0] ticks_now = '0;
   mode_type mode_now = MODE_IDLE;
   logic dir_now = 1'b1;
   logic [TRAVEL_W-1:0] travel_now = '0;
   logic home_dir_now = 1'b0;

   motor_result_type result_q[$];
   int items_sent = 0;
   int error_count = 0;
   int cycle_count = 0;
   bit steady_run = 1'b0;

   stepper_move_controller u_dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb: errors");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= steady_run || ($urandom_range(99) >= 32);
   end

   function automatic void step_motor();
      if (dir_now)
         pos_now = pos_now + 1'b1;
      else
         pos_now = pos_now - 1'b1;
   endfunction

   function automatic logic [STAT_W-1:0] home_action(input logic hit, output logic stepped);
      stepped = 1'b0;
      if (mode_now == MODE_SEEK && hit) begin
         dir_now = ~home_dir_now;
         travel_now = '0;
         mode_now = MODE_BACKOFF;
      end
      if (mode_now == MODE_SEEK || hit) begin
         step_motor();
         stepped = 1'b1;
         travel_now = travel_now + 1'b1;
         if (travel_now >= max_steps_cfg) begin
            mode_now = MODE_IDLE;
            return STAT_HOME_FAIL;
         end
         return STAT_NONE;
      end
      dir_now = home_dir_now;
      mode_now = MODE_IDLE;
      pos_now = '0;
      return STAT_HOME_OK;
   endfunction

   function automatic motor_result_type predict_motor(input logic [CMD_W-1:0] cmd,
         input logic [MM_W-1:0] tmm, input logic [MM_W-1:0] smm,
         input logic hdir, input logic es);
      motor_result_type r;
      logic hit;
      logic stepped;
      logic [STAT_W-1:0] stat;
      logic [CNT_W-1:0] period;
      int goal;
      int here;
      int rate;
      int quot;
      hit = (es == endstop_lvl_cfg);
      stepped = 1'b0;
      stat = STAT_NONE;
      here = $signed(pos_now);
      case (cmd)
         CMD_MOVE: begin
            goal = int'(tmm) * int'(spm_cfg);
            if (goal != here) begin
               rate = int'(smm) * int'(spm_cfg);
               if (rate == 0)
                  rate = 1;
               quot = int'(DIV_DIVIDEND) / rate;
               if (quot < int'(MIN_QUOTIENT))
                  interval_now = PULSE_TIME;
               else
                  interval_now = CNT_W'(quot - int'(PULSE_TIME));
               goal_now = GOAL_W'(goal);
               dir_now = goal > here;
               ticks_now = '0;
               mode_now = MODE_MOVE;
            end
         end
         CMD_HOME: begin
            home_dir_now = hdir;
            dir_now = hdir;
            travel_now = '0;
            ticks_now = '0;
            mode_now = MODE_SEEK;
         end
         CMD_TICK: begin
            if (mode_now == MODE_MOVE) begin
               ticks_now = ticks_now + 1'b1;
               if (ticks_now > interval_now) begin
                  ticks_now = '0;
                  if (hit) begin
                     mode_now = MODE_IDLE;
                  end else begin
                     step_motor();
                     stepped = 1'b1;
                     here = $signed(pos_now);
                     if (here <= 0 || here >= int'(max_steps_cfg) || here == int'(goal_now))
                        mode_now = MODE_IDLE;
                  end
               end
            end else if (mode_now != MODE_IDLE) begin
               if (ticks_now == '0)
                  stat = home_action(hit, stepped);
               period = (mode_now == MODE_SEEK) ? SEEK_PERIOD : BACKOFF_PERIOD;
               ticks_now = ticks_now + 1'b1;
               if (ticks_now >= period || mode_now == MODE_IDLE)
                  ticks_now = '0;
            end
         end
         default: ;
      endcase
      r.step_pulse = stepped;
      r.direction = dir_now;
      r.enable = (mode_now != MODE_IDLE);
      r.position = pos_now;
      r.busy = (mode_now != MODE_IDLE);
      r.status = stat;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("tb: %s mismatch at cycle %0d: got %0d, want %0d",
                  what, cycle_count, got, want);
   endtask

   always @(posedge clock) begin : check_rsp
      motor_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (result_q.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
         end else begin
            want = result_q.pop_front();
            if (rsp_step_pulse !== want.step_pulse)
               report_mismatch("step_pulse", rsp_step_pulse, want.step_pulse);
            if (rsp_direction !== want.direction)
               report_mismatch("direction", rsp_direction, want.direction);
            if (rsp_enable !== want.enable)
               report_mismatch("enable", rsp_enable, want.enable);
            if (rsp_position !== want.position)
               report_mismatch("position", rsp_position, $signed(want.position));
            if (rsp_busy_res !== want.busy)
               report_mismatch("busy_res", rsp_busy_res, want.busy);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
         end
      end
   end

   // all driving tasks start and end at a falling edge
   task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [MM_W-1:0] tmm,
         input logic [MM_W-1:0] smm, input logic hdir, input logic es);
      if (!steady_run && $urandom_range(99) < 32)
         repeat ($urandom_range(1, 4)) @(negedge clock);
      req_valid = 1'b1;
      req_command = cmd;
      req_target_mm = tmm;
      req_speed_mms = smm;
      req_home_dir = hdir;
      req_endstop = es;
      do @(posedge clock); while (!req_ready);
      result_q.push_back(predict_motor(cmd, tmm, smm, hdir, es));
      items_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_tick(input logic es);
      send_beat(CMD_TICK, MM_W'($urandom), MM_W'($urandom), 1'($urandom), es);
   endtask

   // switch starts as pressed says, flipped with a chance of toggle_pm per mille per tick
   task automatic run_ticks(input int count, input bit pressed, input int toggle_pm);
      bit hit_now;
      hit_now = pressed;
      repeat (count) begin
         if ($urandom_range(999) < toggle_pm)
            hit_now = ~hit_now;
         send_tick(hit_now ? endstop_lvl_cfg : ~endstop_lvl_cfg);
      end
   endtask

   task automatic wait_for_drain();
      while (result_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      wait_for_drain();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_STEPS_PER_MM: spm_cfg = data[SPM_W-1:0];
         CSR_MAX_STEPS:    max_steps_cfg = data;
         CSR_ENDSTOP_LVL:  endstop_lvl_cfg = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic test_idle_and_unused();
      send_tick(1'b0);
      send_tick(1'b1);
      send_beat(CMD_UNUSED, '1, '1, 1'b1, 1'b1);
   endtask

   task automatic test_move_commands();
      send_beat(CMD_MOVE, 10'd0, 10'd1023, 1'b0, 1'b0);     // already at goal
      send_beat(CMD_MOVE, 10'd1023, 10'd1023, 1'b1, 1'b1);  // interval floor
      send_tick(1'b1);
      send_beat(CMD_MOVE, 10'd1023, 10'd0, 1'b0, 1'b0);     // zero rate
      send_beat(CMD_MOVE, 10'd1, 10'd1, 1'b0, 1'b0);
      send_tick(~endstop_lvl_cfg);
      send_beat(CMD_UNUSED, 10'd0, 10'd0, 1'b0, 1'b0);
   endtask

   task automatic test_home_commands();
      send_beat(CMD_HOME, 10'd0, 10'd0, 1'b1, 1'b0);
      send_beat(CMD_MOVE, 10'd0, 10'd512, 1'b0, 1'b0);      // goal at position, homing goes on
      send_tick(endstop_lvl_cfg);                           // switch hit: back-off at once
      send_tick(endstop_lvl_cfg);
      send_beat(CMD_HOME, '1, '1, 1'b0, 1'b1);
      send_tick(~endstop_lvl_cfg);
      send_beat(CMD_MOVE, 10'd0, 10'd1023, 1'b0, 1'b0);     // move replaces homing
      send_tick(~endstop_lvl_cfg);
      send_beat(CMD_HOME, 10'd0, 10'd0, 1'b1, 1'b1);        // home replaces move
   endtask

   task automatic test_homing_fail();
      write_reg(CSR_ENDSTOP_LVL, 16'd0);
      write_reg(CSR_MAX_STEPS, 16'd2);
      send_beat(CMD_HOME, MM_W'($urandom), MM_W'($urandom), 1'($urandom), 1'b1);
      run_ticks(600, 1'b0, 0);
      write_reg(CSR_MAX_STEPS, 16'd1);
      send_beat(CMD_HOME, MM_W'($urandom), MM_W'($urandom), 1'($urandom), 1'b0);
      run_ticks(2, 1'b1, 0);
      write_reg(CSR_MAX_STEPS, 16'd0);
      send_beat(CMD_HOME, MM_W'($urandom), MM_W'($urandom), 1'($urandom), 1'b0);
      run_ticks(2, 1'b0, 0);
   endtask

   task automatic test_homing_cycle();
      write_reg(CSR_MAX_STEPS, 16'hFFFF);
      write_reg(CSR_ENDSTOP_LVL, 16'd1);
      send_beat(CMD_HOME, MM_W'($urandom), MM_W'($urandom), 1'($urandom), 1'b0);
      run_ticks($urandom_range(600, 1600), 1'b0, 0);
      run_ticks($urandom_range(3300, 6600), 1'b1, 0);
      run_ticks(3300, 1'b0, 0);
   endtask

   task automatic test_move_to_goal();
      write_reg(CSR_STEPS_PER_MM, 16'd4);
      send_beat(CMD_MOVE, 10'd1, 10'd1023, 1'b0, 1'b0);
      run_ticks(900, 1'b0, 0);
      send_beat(CMD_MOVE, 10'd0, 10'd1023, 1'b1, 1'b0);
      run_ticks(900, 1'b0, 0);
      send_beat(CMD_MOVE, 10'd2, 10'd1023, 1'b0, 1'b0);
      run_ticks(500, 1'b0, 0);
      run_ticks(300, 1'b1, 0);
      write_reg(CSR_MAX_STEPS, 16'd3);
      send_beat(CMD_MOVE, 10'd2, 10'd1023, 1'b0, 1'b0);
      run_ticks(250, 1'b0, 0);
   endtask

   task automatic test_random_traffic();
      int phase_end;
      int pick;
      logic [CSR_DAT_W-1:0] spm_val;
      logic [CSR_DAT_W-1:0] max_val;
      logic [CSR_DAT_W-1:0] lvl_val;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               spm_val = 16'd1;
               max_val = 16'd1;
               lvl_val = 16'd0;
            end
            1: begin
               spm_val = 16'd1600;
               max_val = 16'hFFFF;
               lvl_val = 16'd1;
            end
            default: begin
               spm_val = CSR_DAT_W'(($urandom_range(9) == 0) ? $urandom
                                                              : $urandom_range(1, 40));
               max_val = CSR_DAT_W'(($urandom_range(9) == 0) ? $urandom
                                                              : $urandom_range(1, 200));
               lvl_val = CSR_DAT_W'($urandom_range(1));
            end
         endcase
         write_reg(CSR_STEPS_PER_MM, spm_val);
         write_reg(CSR_MAX_STEPS, max_val);
         write_reg(CSR_ENDSTOP_LVL, lvl_val);
         if (phase == 2)
            write_reg(CSR_UNUSED, CSR_DAT_W'($urandom));
         steady_run = (phase == 3);
         phase_end = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < phase_end) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
               send_beat(CMD_MOVE,
                         MM_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 8)),
                         MM_W'(($urandom_range(4) == 0) ? $urandom
                                                        : $urandom_range(600, 1023)),
                         1'($urandom), 1'($urandom));
               run_ticks(($urandom_range(99) < 20) ? $urandom_range(200, 700)
                                                   : $urandom_range(0, 30),
                         $urandom_range(99) < 3, 2);
            end else if (pick < 80) begin
               send_beat(CMD_HOME, MM_W'($urandom), MM_W'($urandom),
                         1'($urandom), 1'($urandom));
               run_ticks(($urandom_range(99) < 15) ? $urandom_range(500, 1200)
                                                   : $urandom_range(0, 40),
                         $urandom_range(1) != 0, 5);
            end else if (pick < 95) begin
               send_beat(CMD_W'($urandom), MM_W'($urandom), MM_W'($urandom),
                         1'($urandom), 1'($urandom));
            end else begin
               wait_for_drain();
            end
         end
      end
      steady_run = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_idle_and_unused();
      test_move_commands();
      test_home_commands();
      test_homing_fail();
      test_homing_cycle();
      test_move_to_goal();
      test_random_traffic();
      wait_for_drain();
      repeat (40) @(negedge clock);
      if (error_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

/* filelist.f */
rtl/smc_pkg.sv
rtl/smc_div.sv
rtl/smc_ctl.sv
rtl/smc_dp.sv
rtl/stepper_move_controller.sv
sim/tb.sv
